[hdl/mpds_pkg.sv]
// ----------------------------------------------------------------------------
// mpds_pkg: shared types and codes of the duplicate screener
// Verdict codes, register indexes, the scan probe and the control states.
// ----------------------------------------------------------------------------
package mpds_pkg;

   localparam int GROUP_W = 64;
   localparam int DEVICE_W = 64;
   localparam int SEQ_W = 32;
   localparam int CSR_INDEX_W = 8;

   typedef logic [2:0] verdict_type;

   localparam verdict_type VERDICT_REJECTED      = 3'd0;
   localparam verdict_type VERDICT_NEW_LOCAL     = 3'd1;
   localparam verdict_type VERDICT_NEW_FOREIGN   = 3'd2;
   localparam verdict_type VERDICT_STALE_LOCAL   = 3'd3;
   localparam verdict_type VERDICT_STALE_FOREIGN = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_LOCAL_GROUP  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOCAL_DEVICE = 8'd1;

   // Packet identity and scan outcome as it moves down the row of cells
   typedef struct packed {
      logic [GROUP_W-1:0]  pkt_group;
      logic [DEVICE_W-1:0] origin_device;
      logic [SEQ_W-1:0]    pkt_seq;
      logic                done;      // source found or appended
      logic                is_new;    // verdict is new rather than stale
      logic                appended;  // a free cell took the source
   } probe_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[hdl/mpds_cell.sv]
// ----------------------------------------------------------------------------
// mpds_cell: one source entry of the screener
// Holds one group/device pair with its latest sequence number, checks the
// passing probe against it and hands the probe on in the next cycle.
// ----------------------------------------------------------------------------
module mpds_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_W-1:0]      fill_count,
   input  logic                  in_valid,
   input  mpds_pkg::probe_type   in_probe,
   output logic                  out_valid,
   output mpds_pkg::probe_type   out_probe
);

   logic [mpds_pkg::GROUP_W-1:0]  ent_group_ff;
   logic [mpds_pkg::DEVICE_W-1:0] ent_device_ff;
   logic [mpds_pkg::SEQ_W-1:0]    ent_seq_ff;

   logic                valid_ff;
   mpds_pkg::probe_type probe_ff;
   mpds_pkg::probe_type probe_in;

   logic searching;
   logic hit;
   logic newer;
   logic append;

   assign searching = in_valid && !in_probe.done;
   assign hit = searching && (CNT_W'(INDEX) < fill_count)
      && (ent_group_ff == in_probe.pkt_group)
      && (ent_device_ff == in_probe.origin_device);
   assign newer = in_probe.pkt_seq > ent_seq_ff;
   // first free cell takes an unknown source
   assign append = searching && (CNT_W'(INDEX) == fill_count);

   always_comb begin
      probe_in = in_probe;
      probe_in.done = in_probe.done | hit | append;
      probe_in.is_new = in_probe.is_new | (hit & newer) | append;
      probe_in.appended = in_probe.appended | append;
   end

   always_ff @(posedge clock) begin
      if (append) begin
         ent_group_ff <= in_probe.pkt_group;
         ent_device_ff <= in_probe.origin_device;
         ent_seq_ff <= in_probe.pkt_seq;
      end else if (hit && newer) begin
         ent_seq_ff <= in_probe.pkt_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         probe_ff <= probe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_probe = probe_ff;

endmodule

[hdl/mesh_packet_duplicate_screener_top.sv]
// ----------------------------------------------------------------------------
// mesh_packet_duplicate_screener_top: sequence number duplicate screener
// Row of source cells scanned by a travelling probe, with result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one packet identity per transfer (group, origin device,
//   sequence number). rsp_* returns one verdict per request, in order.
//   csr_* writes local_group (index 0) or local_device (index 1); other
//   indexes are ignored. Write only while no request is in flight.
// Flow:
//   A packet from the local device skips the scan: the finish state loads
//   its verdict into the output register. Any other packet walks the row of
//   MAX_SOURCES cells, one cell a cycle, then passes the finish state. One
//   request is in flight at a time: a new one can be taken in the cycle
//   after the verdict is loaded.
// Reset:
//   Clears both registers, the fill count and all handshake state. Entry
//   contents are left as they are; cells at or above the fill count are
//   never matched.
// Stall:
//   A verdict waits in the output register while rsp_tready is low; the
//   next request is still taken and scanned, and holds in the finish state
//   until the output register frees up.
// ----------------------------------------------------------------------------
module mesh_packet_duplicate_screener_top #(
   parameter int MAX_SOURCES = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // pkt_group[63:0], origin_device[127:64],
                                     // pkt_seq[159:128]
   // verdict stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // verdict[2:0], zero fill [7:3]
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   // configuration registers
   logic [mpds_pkg::GROUP_W-1:0]  local_group_ff;
   logic [mpds_pkg::DEVICE_W-1:0] local_device_ff;

   // control
   mpds_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]      fill_count_ff, fill_count_in;
   mpds_pkg::verdict_type pending_ff, pending_in;
   logic                  launch_ff, launch_in;
   mpds_pkg::probe_type   launch_probe_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   mpds_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;

   // probe path through the row: element 0 is the launch register
   logic                chain_valid [MAX_SOURCES+1];
   mpds_pkg::probe_type chain_probe [MAX_SOURCES+1];

   logic                req_fire;
   logic                local_origin;
   logic                tail_valid;
   mpds_pkg::probe_type tail_probe;
   logic                tail_local;
   logic                rsp_free;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == mpds_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign local_origin = (req_tdata[127:64] == local_device_ff);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {5'd0, rsp_verdict_ff};
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         local_group_ff <= '0;
         local_device_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mpds_pkg::REG_LOCAL_GROUP:  local_group_ff <= csr_data;
            mpds_pkg::REG_LOCAL_DEVICE: local_device_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // launch the probe with a clean outcome
   always_ff @(posedge clock) begin
      if (req_fire) begin
         launch_probe_ff.pkt_group <= req_tdata[63:0];
         launch_probe_ff.origin_device <= req_tdata[127:64];
         launch_probe_ff.pkt_seq <= req_tdata[159:128];
         launch_probe_ff.done <= 1'b0;
         launch_probe_ff.is_new <= 1'b0;
         launch_probe_ff.appended <= 1'b0;
      end
   end

   assign chain_valid[0] = launch_ff;
   assign chain_probe[0] = launch_probe_ff;

   for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
      mpds_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .fill_count (fill_count_ff),
         .in_valid   (chain_valid[i]),
         .in_probe   (chain_probe[i]),
         .out_valid  (chain_valid[i+1]),
         .out_probe  (chain_probe[i+1])
      );
   end

   assign tail_valid = chain_valid[MAX_SOURCES];
   assign tail_probe = chain_probe[MAX_SOURCES];
   assign tail_local = (tail_probe.pkt_group == local_group_ff);

   always_comb begin
      state_in = state_ff;
      fill_count_in = fill_count_ff;
      pending_in = pending_ff;
      launch_in = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_verdict_in = rsp_verdict_ff;
      unique case (state_ff)
         mpds_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (local_origin) begin
                  // drop packets from this node without a scan
                  pending_in = mpds_pkg::VERDICT_REJECTED;
                  state_in = mpds_pkg::ST_FINISH;
               end else begin
                  launch_in = 1'b1;
                  state_in = mpds_pkg::ST_SCAN;
               end
            end
         end
         mpds_pkg::ST_SCAN: begin
            if (tail_valid) begin
               if (!tail_probe.done) begin
                  // unknown source and no free cell
                  pending_in = mpds_pkg::VERDICT_REJECTED;
               end else if (tail_probe.is_new) begin
                  pending_in = tail_local ? mpds_pkg::VERDICT_NEW_LOCAL
                                          : mpds_pkg::VERDICT_NEW_FOREIGN;
               end else begin
                  pending_in = tail_local ? mpds_pkg::VERDICT_STALE_LOCAL
                                          : mpds_pkg::VERDICT_STALE_FOREIGN;
               end
               if (tail_probe.appended) begin
                  fill_count_in = fill_count_ff + CNT_W'(1);
               end
               state_in = mpds_pkg::ST_FINISH;
            end
         end
         mpds_pkg::ST_FINISH: begin
            // hold the verdict until the output register frees up
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_verdict_in = pending_ff;
               state_in = mpds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpds_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpds_pkg::ST_IDLE;
         fill_count_ff <= '0;
         launch_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_count_ff <= fill_count_in;
         launch_ff <= launch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != mpds_pkg::ST_IDLE)
      else $error("request taken but control stayed idle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(MAX_SOURCES))
      else $error("fill count beyond the number of cells");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_valid |-> state_ff == mpds_pkg::ST_SCAN)
      else $error("probe left the row outside a scan");

   a_launch_in_scan: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> state_ff == mpds_pkg::ST_SCAN && !tail_valid)
      else $error("probe launched outside a scan");
`endif

endmodule
